### src/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg: shared types and constants of the Huffman bit packer
// Item codes, field widths and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned LEN_IN_W   = 6;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 40;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 24'd4096;

  typedef struct packed {
    logic tbl_wr;   // write table entry from the input item
    logic tbl_rd;   // look up the input item's symbol
    logic load_w;   // merge held bits and code into the pack register
    logic pack;     // send one byte from the pack register
    logic settle;   // park leftover bits in the accumulator
    logic bad;      // report an unusable symbol
    logic pad;      // send the zero-padded partial byte
    logic fin;      // send the summary and start a new message
  } hbp_cmd_t;

  typedef struct packed {
    logic err;
    logic bad_sym;
    logic t_ge8;
    logic pend_nz;
    logic over_cap;
    logic can_emit;
  } hbp_sts_t;

endpackage

`default_nettype wire

### src/hbp_ram.sv
// ----------------------------------------------------------------------------
// hbp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/hbp_ctrl.sv
// ----------------------------------------------------------------------------
// hbp_ctrl: sequencing controller of the Huffman bit packer
// Takes one input item at a time and steps the datapath through lookup,
// byte packing, padding and the end-of-message summary.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  input  wire logic [1:0]        s_mode_i,
  output logic                   s_tready_o,
  input  wire hbp_pkg::hbp_sts_t sts_i,
  output hbp_pkg::hbp_cmd_t      cmd_o
);

  import hbp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_BAD,
    ST_PACK,
    ST_PAD,
    ST_END
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign s_tready_o = (state_q == ST_IDLE);
  assign fire       = s_tvalid_i && s_tready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          case (s_mode_i)
            MODE_LOAD: cmd_o.tbl_wr = 1'b1;
            MODE_ENCODE: begin
              if (!sts_i.err) begin
                cmd_o.tbl_rd = 1'b1;
                state_d      = ST_LOOK;
              end
            end
            MODE_FLUSH: state_d = (!sts_i.err && sts_i.pend_nz) ? ST_PAD : ST_END;
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        if (sts_i.bad_sym) begin
          state_d = ST_BAD;
        end else begin
          cmd_o.load_w = 1'b1;
          state_d      = ST_PACK;
        end
      end
      ST_BAD: begin
        if (sts_i.can_emit) begin
          cmd_o.bad = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_PACK: begin
        if (sts_i.t_ge8) begin
          if (sts_i.can_emit) begin
            cmd_o.pack = 1'b1;
            // a capacity error ends the item; the rest of its bits drop
            if (sts_i.over_cap) state_d = ST_IDLE;
          end
        end else begin
          cmd_o.settle = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (sts_i.can_emit) begin
          cmd_o.pad = 1'b1;
          state_d   = ST_END;
        end
      end
      ST_END: begin
        if (sts_i.can_emit) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/hbp_dp.sv
// ----------------------------------------------------------------------------
// hbp_dp: datapath of the Huffman bit packer
// Code table with entry valid bits, bit accumulator, pack register,
// byte counter, capacity register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbp_dp #(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire hbp_pkg::hbp_cmd_t               cmd_i,
  output hbp_pkg::hbp_sts_t                    sts_o,
  input  wire logic [hbp_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic [hbp_pkg::CNT_W-1:0]       cfg_data_i,
  input  wire logic                            m_tready_i,
  output logic                                 m_valid_o,
  output logic [1:0]                           m_kind_o,
  output logic [7:0]                           m_byte_o,
  output logic [hbp_pkg::CNT_W-1:0]            m_count_o,
  output logic                                 m_failed_o,
  output logic                                 m_last_o
);

  import hbp_pkg::*;

  localparam int unsigned AW = $clog2(SYMBOL_COUNT);
  localparam int unsigned LW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned WW = MAX_CODE_BITS + 8;
  localparam int unsigned TW = $clog2(WW);
  localparam int unsigned EW = LW + MAX_CODE_BITS;
  localparam logic [SYM_W:0]      SymLimit = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_IN_W-1:0] MaxLen   = LEN_IN_W'(MAX_CODE_BITS);

  // input item fields
  logic [SYM_W-1:0]    in_sym;
  logic [CODE_W-1:0]   in_code;
  logic [LEN_IN_W-1:0] in_len;
  logic [LEN_IN_W-1:0] len_cl;
  logic                sym_ok;
  logic [AW-1:0]       addr;

  assign in_sym  = s_tdata_i[SYM_W-1:0];
  assign in_code = s_tdata_i[SYM_W+CODE_W-1:SYM_W];
  assign in_len  = s_tdata_i[SYM_W+CODE_W+LEN_IN_W-1:SYM_W+CODE_W];
  assign len_cl  = (in_len > MaxLen) ? MaxLen : in_len;
  assign sym_ok  = ({1'b0, in_sym} < SymLimit);
  assign addr    = in_sym[AW-1:0];

  // code table: RAM plus one valid bit per entry, cleared at reset
  logic [SYMBOL_COUNT-1:0] vld_q;
  logic                    ent_ok_q;
  logic [EW-1:0]           rd_ent;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LW-1:0]           rd_len;

  hbp_ram #(
    .WIDTH (EW),
    .DEPTH (SYMBOL_COUNT)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tbl_wr && sym_ok),
    .waddr_i (addr),
    .wdata_i ({LW'(len_cl), in_code[MAX_CODE_BITS-1:0]}),
    .re_i    (cmd_i.tbl_rd),
    .raddr_i (addr),
    .rdata_o (rd_ent)
  );

  assign rd_code = rd_ent[MAX_CODE_BITS-1:0];
  assign rd_len  = ent_ok_q ? rd_ent[EW-1:MAX_CODE_BITS] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ent_ok_q <= 1'b0;
    end else begin
      if (cmd_i.tbl_wr && sym_ok) vld_q[addr] <= 1'b1;
      if (cmd_i.tbl_rd) ent_ok_q <= sym_ok && vld_q[addr];
    end
  end

  // message state
  logic [7:0]       acc_q;       // held bits, left aligned
  logic [2:0]       pend_q;
  logic [CNT_W-1:0] emitted_q;
  logic             err_q;
  logic [CNT_W-1:0] cap_q;
  logic [WW-1:0]    w_q;         // pack register, next bit in the MSB
  logic [TW-1:0]    t_q;         // bits held in the pack register

  logic [WW-1:0]    code_ext;
  logic [LW-1:0]    shl;
  logic [WW-1:0]    w_new;
  logic [TW-1:0]    t_new;
  logic [TW-1:0]    t_rem;
  logic             over_cap;
  logic [CNT_W-1:0] emitted_inc;

  assign code_ext    = {rd_code, 8'b0};
  assign shl         = LW'(MAX_CODE_BITS) - rd_len;
  assign w_new       = {acc_q, {MAX_CODE_BITS{1'b0}}} | ((code_ext << shl) >> pend_q);
  assign t_new       = TW'(pend_q) + TW'(rd_len);
  assign t_rem       = t_q - TW'(8);
  assign over_cap    = (emitted_q >= cap_q);
  assign emitted_inc = emitted_q + CNT_W'(1);

  // output register
  logic             out_vld_q;
  logic [1:0]       out_kind_q;
  logic [7:0]       out_byte_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_failed_q;
  logic             out_last_q;
  logic             emit;

  assign emit = cmd_i.pack || cmd_i.bad || cmd_i.pad || cmd_i.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      pend_q    <= '0;
      emitted_q <= '0;
      err_q     <= 1'b0;
      cap_q     <= CAP_RESET;
      t_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;

      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end

      if (cmd_i.load_w) begin
        t_q <= t_new;
      end

      if (cmd_i.pack) begin
        if (over_cap) begin
          err_q  <= 1'b1;
          acc_q  <= '0;
          pend_q <= '0;
          t_q    <= '0;
        end else begin
          emitted_q <= emitted_inc;
          t_q       <= t_rem;
        end
      end

      if (cmd_i.settle) begin
        acc_q  <= w_q[WW-1 -: 8];
        pend_q <= t_q[2:0];
      end

      if (cmd_i.bad) err_q <= 1'b1;

      if (cmd_i.pad) begin
        if (over_cap) begin
          err_q <= 1'b1;
        end else begin
          emitted_q <= emitted_inc;
        end
      end

      if (cmd_i.fin) begin
        acc_q     <= '0;
        pend_q    <= '0;
        emitted_q <= '0;
        err_q     <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_w) begin
      w_q <= w_new;
    end else if (cmd_i.pack) begin
      w_q <= w_q << 8;
    end

    if (cmd_i.pack) begin
      out_kind_q   <= over_cap ? KIND_ERROR : KIND_DATA;
      out_byte_q   <= over_cap ? 8'd0 : w_q[WW-1 -: 8];
      out_count_q  <= over_cap ? emitted_q : emitted_inc;
      out_failed_q <= over_cap;
      out_last_q   <= over_cap || (t_rem < TW'(8));
    end else if (cmd_i.bad) begin
      out_kind_q   <= KIND_ERROR;
      out_byte_q   <= 8'd0;
      out_count_q  <= emitted_q;
      out_failed_q <= 1'b1;
      out_last_q   <= 1'b1;
    end else if (cmd_i.pad) begin
      out_kind_q   <= over_cap ? KIND_ERROR : KIND_DATA;
      out_byte_q   <= over_cap ? 8'd0 : acc_q;
      out_count_q  <= over_cap ? emitted_q : emitted_inc;
      out_failed_q <= over_cap;
      out_last_q   <= 1'b0;
    end else if (cmd_i.fin) begin
      out_kind_q   <= KIND_END;
      out_byte_q   <= 8'd0;
      out_count_q  <= emitted_q;
      out_failed_q <= err_q;
      out_last_q   <= 1'b1;
    end
  end

  assign sts_o.err      = err_q;
  assign sts_o.bad_sym  = (rd_len == '0);
  assign sts_o.t_ge8    = (t_q >= TW'(8));
  assign sts_o.pend_nz  = (pend_q != 3'd0);
  assign sts_o.over_cap = over_cap;
  assign sts_o.can_emit = !out_vld_q || m_tready_i;

  assign m_valid_o  = out_vld_q;
  assign m_kind_o   = out_kind_q;
  assign m_byte_o   = out_byte_q;
  assign m_count_o  = out_count_q;
  assign m_failed_o = out_failed_q;
  assign m_last_o   = out_last_q;

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_vld_q || m_tready_i))
    else $error("result issued while output register is occupied");

  a_settle_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |-> (t_q < TW'(8)))
    else $error("full byte left in pack register at settle");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == KIND_END) |-> (emitted_q == '0 && !err_q))
    else $error("message state not cleared after summary");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == KIND_DATA) |-> (!out_failed_q && out_count_q != '0))
    else $error("data byte with failed flag or zero count");

endmodule

`default_nettype wire

### src/huffman_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_bit_packer: table-driven Huffman encoder with MSB-first packing
// Top level; joins the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser is the mode (load entry, encode, flush);
// tdata carries symbol, code word and code length. Output stream (m_axis):
// tuser is the result kind (data byte, error, summary), tlast marks the
// final result of an input item. Config channel writes output_capacity.
// One item is in work at a time. An encode completes 0..4 bytes in steps:
// accept with table read, merge into the pack register, one byte per cycle
// while the output register is free, then park leftover bits; the table
// RAM's read is registered. A flush sends the padded byte, if bits are
// held and no error is set, and then the summary.
// The output register lets an item be accepted while a result waits; when
// the receiver stalls, byte production stops until the register frees.
// Reset clears the entry valid bits (all entries read as unused), message
// state, and sets capacity to 4096; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_bit_packer #(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
  input  wire logic [hbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // out_byte[7:0], byte_count[31:8], failed[32], zero pad
  output logic [hbp_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hbp_pkg::CNT_W-1:0]     cfg_data_i
);

  import hbp_pkg::*;

  hbp_cmd_t         cmd;
  hbp_sts_t         sts;
  logic [7:0]       out_byte;
  logic [CNT_W-1:0] out_count;
  logic             out_failed;

  hbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_mode_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hbp_dp #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_kind_o    (m_axis_tuser),
    .m_byte_o    (out_byte),
    .m_count_o   (out_count),
    .m_failed_o  (out_failed),
    .m_last_o    (m_axis_tlast)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {7'b0, out_failed, out_count, out_byte};

endmodule

`default_nettype wire

### verif/tb_huffman_bit_packer.sv
// ----------------------------------------------------------------------------
// tb_huffman_bit_packer: self-checking bench for the Huffman bit packer
// Loads code table entries, encodes symbols and flushes messages over the
// input stream, with random gaps and output stalls. Every output transfer
// is checked field by field against an in-bench packer model. Output
// capacity is swept between messages, including 1 and its largest
// value.
// ----------------------------------------------------------------------------

module tb_huffman_bit_packer;

  import hbp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned STALL_MAX  = 6;
  localparam int unsigned SETTLE_CYC = 12;   // outlasts the longest encode
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYC   = 300;
  localparam int unsigned RAND_ITEMS = 45;   // per capacity setting
  localparam int unsigned MAX_REPORT = 10;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] count;
    logic             failed;
    logic             last;
  } pack_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CNT_W-1:0]       cfg_data_i;

  // packer model state
  logic [CODE_W-1:0]      code_tbl [256];
  int unsigned            len_tbl  [256];
  logic [7:0]             acc_bits;
  int unsigned            acc_count;
  logic [CNT_W-1:0]       msg_bytes;
  logic                   msg_failed;
  logic [CNT_W-1:0]       cap_limit;

  pack_result_t           expected_out [$];

  int unsigned            items_sent;
  int unsigned            results_seen;
  int unsigned            mismatches;
  int unsigned            cap_settings;
  bit                     tx_idle_en;
  bit                     rx_idle_en;
  int unsigned            rx_hold_req;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  huffman_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------- model

  function automatic void add_result(logic [1:0] kind, logic [7:0] data_byte,
                                     logic [CNT_W-1:0] count, logic failed);
    pack_result_t r;
    r.kind      = kind;
    r.data_byte = data_byte;
    r.count     = count;
    r.failed    = failed;
    r.last      = 1'b0;
    expected_out.push_back(r);
  endfunction

  // a completed byte either goes out or trips the capacity error
  function automatic bit emit_byte(logic [7:0] data_byte);
    if (msg_bytes >= cap_limit) begin
      msg_failed = 1'b1;
      add_result(KIND_ERROR, 8'h00, msg_bytes, 1'b1);
      return 1'b0;
    end
    msg_bytes = msg_bytes + 1'b1;
    add_result(KIND_DATA, data_byte, msg_bytes, 1'b0);
    return 1'b1;
  endfunction

  function automatic void pack_item(logic [1:0] mode, logic [7:0] sym,
                                    logic [CODE_W-1:0] word, logic [5:0] len);
    int unsigned n;
    int unsigned start;
    case (mode)
      MODE_LOAD: begin
        code_tbl[sym] = word;
        len_tbl[sym]  = (len > 6'd32) ? 32 : len;
      end
      MODE_ENCODE: begin
        if (msg_failed) return;
        start = expected_out.size();
        if (len_tbl[sym] == 0) begin
          msg_failed = 1'b1;
          add_result(KIND_ERROR, 8'h00, msg_bytes, 1'b1);
        end else begin
          n = len_tbl[sym];
          for (int i = n; i > 0; i--) begin
            acc_bits  = {acc_bits[6:0], code_tbl[sym][i-1]};
            acc_count = acc_count + 1;
            if (acc_count == 8) begin
              acc_count = 0;
              if (!emit_byte(acc_bits)) begin
                acc_bits = 8'h00;
                break;
              end
              acc_bits = 8'h00;
            end
          end
        end
        if (expected_out.size() > start) expected_out[$].last = 1'b1;
      end
      MODE_FLUSH: begin
        if (!msg_failed && acc_count > 0) begin
          void'(emit_byte(acc_bits << (8 - acc_count)));
        end
        add_result(KIND_END, 8'h00, msg_bytes, msg_failed);
        expected_out[$].last = 1'b1;
        acc_bits   = 8'h00;
        acc_count  = 0;
        msg_bytes  = '0;
        msg_failed = 1'b0;
      end
      default: ;  // unused mode does nothing
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic push_item(logic [1:0] mode, logic [7:0] sym,
                           logic [CODE_W-1:0] word, logic [5:0] len);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(STALL_MAX, 0) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, len, word, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pack_item(mode, sym, word, len);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic load_entry(logic [7:0] sym, logic [CODE_W-1:0] word, logic [5:0] len);
    push_item(MODE_LOAD, sym, word, len);
  endtask

  task automatic encode_sym(logic [7:0] sym);
    push_item(MODE_ENCODE, sym, $urandom(), 6'($urandom()));
  endtask

  task automatic flush_msg();
    push_item(MODE_FLUSH, 8'($urandom()), $urandom(), 6'($urandom()));
  endtask

  // stop offering, wait until every expected result is out, then let a
  // trailing load settle in the block
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_out.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_limit = cap;
    cap_settings++;
  endtask

  // mostly symbols that hold a code, now and then anything
  function automatic logic [7:0] pick_symbol();
    logic [7:0] s;
    s = 8'($urandom());
    for (int t = 0; t < 16; t++) begin
      if (len_tbl[s] != 0) return s;
      s = 8'($urandom());
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    pack_result_t got;
    pack_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind      = m_axis_tuser;
      got.data_byte = m_axis_tdata[7:0];
      got.count     = m_axis_tdata[31:8];
      got.failed    = m_axis_tdata[32];
      got.last      = m_axis_tlast;
      results_seen++;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("[%0t] unexpected result kind=%0d byte=%02h count=%0d failed=%0b last=%0b",
                   $realtime, got.kind, got.data_byte, got.count, got.failed, got.last);
      end else begin
        want = expected_out.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("[%0t] mismatch exp kind=%0d byte=%02h count=%0d failed=%0b last=%0b",
                     $realtime, want.kind, want.data_byte, want.count, want.failed,
                     want.last, "\n           got kind=%0d byte=%02h count=%0d failed=%0b last=%0b",
                     got.kind, got.data_byte, got.count, got.failed, got.last);
        end
      end
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(STALL_MAX, 0) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, expected_out.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // empty table after reset: errors are sticky until the flush
  task automatic test_unloaded_table();
    encode_sym(8'h11);
    encode_sym(8'h22);
    flush_msg();
    flush_msg();
    drain();
  endtask

  task automatic test_code_extremes();
    load_entry(8'h00, 32'h0000_0001, 6'd1);
    load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
    load_entry(8'h5A, 32'h0000_00A5, 6'd8);
    load_entry(8'h80, 32'h0000_0000, 6'd16);
    load_entry(8'h03, 32'h1234_5678, 6'd40);   // overlong, clamps to 32
    load_entry(8'h07, 32'hFFFF_FFFF, 6'd0);    // zero length marks unused
    push_item(MODE_UNUSED, 8'h00, 32'hFFFF_FFFF, 6'd5);
    encode_sym(8'hFF);
    encode_sym(8'h00);
    encode_sym(8'h5A);
    encode_sym(8'h80);
    encode_sym(8'h03);
    encode_sym(8'h07);
    encode_sym(8'h00);
    flush_msg();
    encode_sym(8'h00);
    flush_msg();
    drain();
  endtask

  // capacity of one byte: overflow on a full byte and on the padded byte
  task automatic test_capacity_edge();
    set_capacity(24'd1);
    encode_sym(8'h5A);
    encode_sym(8'h00);
    flush_msg();
    encode_sym(8'h5A);
    encode_sym(8'hFF);
    flush_msg();
    drain();
  endtask

  // receiver holds off long enough for the block to back up its input
  task automatic test_backpressure();
    set_capacity(24'hFF_FFFF);
    tx_idle_en  = 1'b0;
    rx_hold_req = HOLD_CYC;
    for (int i = 0; i < 30; i++) encode_sym(pick_symbol());
    flush_msg();
    drain();
    tx_idle_en = 1'b1;
  endtask

  task automatic run_messages(int unsigned count);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 15)
        load_entry(8'($urandom()), $urandom(),
                   ($urandom_range(9, 0) == 0) ? 6'd0 : 6'($urandom_range(32, 1)));
      else if (roll < 86)
        encode_sym(pick_symbol());
      else if (roll < 96)
        flush_msg();
      else if (roll < 98)
        encode_sym(8'($urandom()));
      else
        push_item(MODE_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()));
    end
    flush_msg();
  endtask

  task automatic test_random_capacity();
    logic [CNT_W-1:0] caps [7];
    caps = '{CAP_RESET, 24'd2, 24'd3, 24'hFF_FFFF,
             24'($urandom_range(40, 4)), 24'd1, 24'($urandom_range(24'hFF_FFFF, 1))};
    for (int p = 0; p < 7; p++) begin
      tx_idle_en = (p != 2);
      rx_idle_en = (p != 2) && (p != 4);
      set_capacity(caps[p]);
      run_messages(RAND_ITEMS);
      drain();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    for (int i = 0; i < 256; i++) begin
      code_tbl[i] = '0;
      len_tbl[i]  = 0;
    end
    acc_bits      = 8'h00;
    acc_count     = 0;
    msg_bytes     = '0;
    msg_failed    = 1'b0;
    cap_limit     = CAP_RESET;
    items_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    cap_settings  = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_req   = 0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_LOAD;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unloaded_table();
    test_code_extremes();
    test_capacity_edge();
    test_backpressure();
    test_random_capacity();
    drain();

    $display("Covered %0d input items (loads, encodes, flushes) and %0d output transfers",
             items_sent, results_seen);
    $display("over %0d capacity writes from 1 to 16777215, with gaps, stalls and a long hold-off",
             cap_settings);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_out.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
